// File: sv/assert_macros.svh
// assertion helpers shared by the rtl, clocked on i_clk and quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent and consequent in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/somr_pkg.sv
package somr_pkg;

    // matrix_size register width
    localparam int SIZE_W  = 4;
    // row and column fields
    localparam int COORD_W = 3;
    // element counters, up to 64 elements
    localparam int COUNT_W = 7;

    // top level sequencer
    typedef enum logic [1:0] {
        ST_LOAD   = 2'b01,
        ST_SPIRAL = 2'b10
    } t_state;

    // side of the current ring being read
    typedef enum logic [3:0] {
        PH_RIGHT = 4'b0001,
        PH_DOWN  = 4'b0010,
        PH_LEFT  = 4'b0100,
        PH_UP    = 4'b1000
    } t_phase;

endpackage

// File: sv/spiral_order_matrix_reader.sv
// Spiral-order matrix reader. Takes a square matrix of matrix_size rows and columns
// (0 is taken as 1, anything above MAX_SIZE as MAX_SIZE), one element per input beat in
// row-major order, into a single memory of MAX_SIZE*MAX_SIZE words. The beat carrying
// the last element starts the read-out: every element leaves in clockwise spiral order
// with its row, column and a last flag on the final one. During read-out the input is
// held off and, while the output is not stalled, the sequencer issues one read per
// cycle from the memory's read port. Each result passes through the memory's read
// register and then the output register. Output stalls hold the read-out without loss.
// Writing matrix_size discards a partly loaded matrix. No clearing pass is needed
// after reset.
`include "assert_macros.svh"

module spiral_order_matrix_reader #(
    parameter int MAX_SIZE   = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [somr_pkg::SIZE_W-1:0]         i_cfg_data,
    // element input
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [DATA_WIDTH-1:0]        i_element_value,
    // spiral output
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [DATA_WIDTH-1:0]        o_out_value,
    output logic [somr_pkg::COORD_W-1:0]        o_out_row,
    output logic [somr_pkg::COORD_W-1:0]        o_out_column,
    output logic                                o_last_of_run
);

    localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration and load state
    logic [somr_pkg::SIZE_W-1:0]  r_matrix_size;
    logic [somr_pkg::COUNT_W-1:0] r_load_count;
    logic [somr_pkg::SIZE_W-1:0]  size_used;
    logic [somr_pkg::SIZE_W-1:0]  size_minus_one;
    logic [somr_pkg::COUNT_W-1:0] total;

    // spiral sequencer
    somr_pkg::t_state             r_state, n_state;
    somr_pkg::t_phase             r_phase, n_phase;
    logic [somr_pkg::COORD_W-1:0] r_top, n_top;
    logic [somr_pkg::COORD_W-1:0] r_hi, n_hi;
    logic [somr_pkg::COORD_W-1:0] r_row, n_row;
    logic [somr_pkg::COORD_W-1:0] r_col, n_col;
    logic [somr_pkg::COUNT_W-1:0] r_emit_count, n_emit_count;

    // read pipeline
    logic                         r_pend;
    logic [somr_pkg::COORD_W-1:0] r_pend_row;
    logic [somr_pkg::COORD_W-1:0] r_pend_col;
    logic                         r_pend_last;
    logic                         r_out_valid;
    logic [DATA_WIDTH-1:0]        r_out_value;
    logic [somr_pkg::COORD_W-1:0] r_out_row;
    logic [somr_pkg::COORD_W-1:0] r_out_col;
    logic                         r_out_last;

    logic                         in_accept;
    logic                         load_done;
    logic                         pend_adv;
    logic                         rd_issue;
    logic                         last_now;
    logic [somr_pkg::COUNT_W-1:0] rd_index;
    logic [DATA_WIDTH-1:0]        ram_rdata;

    // terms used by the checks
    logic                         in_load;
    logic                         in_spiral;
    logic                         walk_inside;
    logic                         issue_last;
    logic                         read_stall;

    // size in use, clamped to 1..MAX_SIZE
    always_comb begin
        size_used = r_matrix_size;
        if (r_matrix_size == '0) begin
            size_used = somr_pkg::SIZE_W'(1);
        end else if (r_matrix_size > somr_pkg::SIZE_W'(MAX_SIZE)) begin
            size_used = somr_pkg::SIZE_W'(MAX_SIZE);
        end
    end

    assign size_minus_one = size_used - somr_pkg::SIZE_W'(1);
    assign total = somr_pkg::COUNT_W'(size_used) * somr_pkg::COUNT_W'(size_used);

    // handshakes; the input is held off while the spiral is read so no
    // load can overwrite an entry still to be read
    assign o_in_ready = (r_state == somr_pkg::ST_LOAD);
    assign in_accept  = i_in_valid && o_in_ready;
    assign load_done  = (r_load_count == total - somr_pkg::COUNT_W'(1));
    assign pend_adv   = r_pend && (!r_out_valid || i_out_ready);
    assign rd_issue   = (r_state == somr_pkg::ST_SPIRAL) && (!r_pend || pend_adv);
    assign last_now   = (r_emit_count == total - somr_pkg::COUNT_W'(1));

    // row-major read address
    assign rd_index = somr_pkg::COUNT_W'(r_row) * somr_pkg::COUNT_W'(size_used)
                    + somr_pkg::COUNT_W'(r_col);

    // configuration register and load counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= somr_pkg::SIZE_W'(8);
            r_load_count  <= '0;
        end else if (i_cfg_we) begin
            r_matrix_size <= i_cfg_data;
            r_load_count  <= '0;
        end else if (in_accept) begin
            if (load_done) begin
                r_load_count <= '0;
            end else begin
                r_load_count <= r_load_count + somr_pkg::COUNT_W'(1);
            end
        end
    end

    // spiral walk: top row right, right column down, bottom row left,
    // left column up, then step one ring inward
    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_top        = r_top;
        n_hi         = r_hi;
        n_row        = r_row;
        n_col        = r_col;
        n_emit_count = r_emit_count;
        unique case (r_state)
            somr_pkg::ST_LOAD: begin
                if (in_accept && load_done) begin
                    n_state      = somr_pkg::ST_SPIRAL;
                    n_phase      = somr_pkg::PH_RIGHT;
                    n_top        = '0;
                    n_hi         = size_minus_one[somr_pkg::COORD_W-1:0];
                    n_row        = '0;
                    n_col        = '0;
                    n_emit_count = '0;
                end
            end
            somr_pkg::ST_SPIRAL: begin
                if (rd_issue) begin
                    n_emit_count = r_emit_count + somr_pkg::COUNT_W'(1);
                    if (last_now) begin
                        n_state = somr_pkg::ST_LOAD;
                    end
                    unique case (r_phase)
                        somr_pkg::PH_RIGHT: begin
                            if (r_col != r_hi) begin
                                n_col = r_col + somr_pkg::COORD_W'(1);
                            end else begin
                                n_phase = somr_pkg::PH_DOWN;
                                n_row   = r_row + somr_pkg::COORD_W'(1);
                            end
                        end
                        somr_pkg::PH_DOWN: begin
                            if (r_row != r_hi) begin
                                n_row = r_row + somr_pkg::COORD_W'(1);
                            end else begin
                                n_phase = somr_pkg::PH_LEFT;
                                n_col   = r_col - somr_pkg::COORD_W'(1);
                            end
                        end
                        somr_pkg::PH_LEFT: begin
                            if (r_col != r_top) begin
                                n_col = r_col - somr_pkg::COORD_W'(1);
                            end else if (r_hi - somr_pkg::COORD_W'(1) > r_top) begin
                                n_phase = somr_pkg::PH_UP;
                                n_row   = r_row - somr_pkg::COORD_W'(1);
                            end else begin
                                n_phase = somr_pkg::PH_RIGHT;
                                n_top   = r_top + somr_pkg::COORD_W'(1);
                                n_hi    = r_hi - somr_pkg::COORD_W'(1);
                                n_row   = r_top + somr_pkg::COORD_W'(1);
                                n_col   = r_top + somr_pkg::COORD_W'(1);
                            end
                        end
                        somr_pkg::PH_UP: begin
                            if (r_row != r_top + somr_pkg::COORD_W'(1)) begin
                                n_row = r_row - somr_pkg::COORD_W'(1);
                            end else begin
                                n_phase = somr_pkg::PH_RIGHT;
                                n_top   = r_top + somr_pkg::COORD_W'(1);
                                n_hi    = r_hi - somr_pkg::COORD_W'(1);
                                n_row   = r_top + somr_pkg::COORD_W'(1);
                                n_col   = r_top + somr_pkg::COORD_W'(1);
                            end
                        end
                        default: begin
                            n_phase = somr_pkg::PH_RIGHT;
                        end
                    endcase
                end
            end
            default: begin
                n_state = somr_pkg::ST_LOAD;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= somr_pkg::ST_LOAD;
            r_phase      <= somr_pkg::PH_RIGHT;
            r_top        <= '0;
            r_hi         <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_emit_count <= '0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_top        <= n_top;
            r_hi         <= n_hi;
            r_row        <= n_row;
            r_col        <= n_col;
            r_emit_count <= n_emit_count;
        end
    end

    // element store
    somr_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_accept),
        .i_waddr (r_load_count[ADDR_W-1:0]),
        .i_wdata (i_element_value),
        .i_re    (rd_issue),
        .i_raddr (rd_index[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // read in flight and output register valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rd_issue) begin
                r_pend <= 1'b1;
            end else if (pend_adv) begin
                r_pend <= 1'b0;
            end
            if (pend_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload of the read in flight and of the output beat
    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_pend_row  <= r_row;
            r_pend_col  <= r_col;
            r_pend_last <= last_now;
        end
        if (pend_adv) begin
            r_out_value <= ram_rdata;
            r_out_row   <= r_pend_row;
            r_out_col   <= r_pend_col;
            r_out_last  <= r_pend_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_value   = r_out_value;
    assign o_out_row     = r_out_row;
    assign o_out_column  = r_out_col;
    assign o_last_of_run = r_out_last;

    // checks
    assign in_load     = (r_state == somr_pkg::ST_LOAD);
    assign in_spiral   = (r_state == somr_pkg::ST_SPIRAL);
    assign walk_inside = (somr_pkg::SIZE_W'(r_row) < size_used)
                       && (somr_pkg::SIZE_W'(r_col) < size_used);
    assign issue_last  = rd_issue && last_now;
    assign read_stall  = r_pend && !pend_adv;

    `ASSERT_SAME(a_load_in_range, in_load, r_load_count < total, "load count past matrix")
    `ASSERT_SAME(a_walk_in_range, in_spiral, walk_inside, "spiral walk left the matrix")
    `ASSERT_NEXT(a_last_ends, issue_last, in_load && r_pend && r_pend_last, "walk kept going")
    `ASSERT_NEXT(a_read_holds, read_stall, r_pend && $stable(ram_rdata), "read data lost")

endmodule

// File: sv/somr_ram.sv
module somr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: tb/tb_spiral_order_matrix_reader.sv
`timescale 1ns / 100ps

module tb_spiral_order_matrix_reader;

    localparam int MAX_SIZE      = 8;
    localparam int DATA_WIDTH    = 32;
    localparam int STORE_DEPTH   = MAX_SIZE * MAX_SIZE;
    localparam int DIR_ROWS      = 27;
    localparam int RAND_ITEMS    = 250;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_PCT      = 35;
    localparam int REPORT_LIMIT  = 10;

    // one output beat of the spiral
    typedef struct packed {
        logic [DATA_WIDTH-1:0]         value;
        logic [somr_pkg::COORD_W-1:0]  row;
        logic [somr_pkg::COORD_W-1:0]  column;
        logic                          last;
    } t_spiral_beat;

    typedef enum logic {
        ROW_SIZE,
        ROW_ELEM
    } t_row_kind;

    // directed row: a size write or an element, optionally with its result typed in
    typedef struct packed {
        t_row_kind             kind;
        logic [DATA_WIDTH-1:0] data;
        logic                  fixed;
        t_spiral_beat          beat;
    } t_stim_row;

    logic                          i_clk;
    logic                          i_rst_n         = 1'b0;
    logic                          i_cfg_we        = 1'b0;
    logic [somr_pkg::SIZE_W-1:0]   i_cfg_data      = '0;
    logic                          i_in_valid      = 1'b0;
    logic                          o_in_ready;
    logic signed [DATA_WIDTH-1:0]  i_element_value = '0;
    logic                          o_out_valid;
    logic                          i_out_ready     = 1'b0;
    logic signed [DATA_WIDTH-1:0]  o_out_value;
    logic [somr_pkg::COORD_W-1:0]  o_out_row;
    logic [somr_pkg::COORD_W-1:0]  o_out_column;
    logic                          o_last_of_run;

    // predictor state
    logic [DATA_WIDTH-1:0]         mat_store [STORE_DEPTH];
    int unsigned                   fill_count  = 0;
    logic [somr_pkg::SIZE_W-1:0]   size_reg    = 4'd8;
    t_spiral_beat                  fresh_beats [$];
    t_spiral_beat                  spiral_expect_q [$];

    int unsigned elem_sent   = 0;
    int unsigned fault_count = 0;
    int unsigned hold_left   = 0;
    bit          hold_done   = 1'b0;

    // stretch of the run with no idling on either side
    wire calm = (elem_sent >= 170) && (elem_sent < 250);

    t_stim_row dir_table [DIR_ROWS] = '{
        // partial load at the reset size, dropped by the size write
        '{ROW_ELEM, 32'h0000_0001, 1'b0, '0},
        '{ROW_ELEM, 32'ha5a5_a5a5, 1'b0, '0},
        '{ROW_ELEM, 32'h5a5a_5a5a, 1'b0, '0},
        // one by one matrices, field extremes
        '{ROW_SIZE, 32'd1,         1'b0, '0},
        '{ROW_ELEM, 32'h7fff_ffff, 1'b1, '{32'h7fff_ffff, 3'd0, 3'd0, 1'b1}},
        '{ROW_ELEM, 32'h8000_0000, 1'b1, '{32'h8000_0000, 3'd0, 3'd0, 1'b1}},
        // size zero taken as one
        '{ROW_SIZE, 32'd0,         1'b0, '0},
        '{ROW_ELEM, 32'h0000_0000, 1'b1, '{32'h0000_0000, 3'd0, 3'd0, 1'b1}},
        '{ROW_ELEM, 32'hffff_ffff, 1'b1, '{32'hffff_ffff, 3'd0, 3'd0, 1'b1}},
        // two by two, even ring only
        '{ROW_SIZE, 32'd2,         1'b0, '0},
        '{ROW_ELEM, 32'h0000_0011, 1'b0, '0},
        '{ROW_ELEM, 32'h0000_0022, 1'b0, '0},
        '{ROW_ELEM, 32'h0000_0033, 1'b0, '0},
        '{ROW_ELEM, 32'h0000_0044, 1'b0, '0},
        // three by three with a partial load dropped by rewriting the same size
        '{ROW_SIZE, 32'd3,         1'b0, '0},
        '{ROW_ELEM, 32'hdead_beef, 1'b0, '0},
        '{ROW_ELEM, 32'hcafe_f00d, 1'b0, '0},
        '{ROW_SIZE, 32'd3,         1'b0, '0},
        '{ROW_ELEM, 32'h0000_0101, 1'b0, '0},
        '{ROW_ELEM, 32'h0000_0102, 1'b0, '0},
        '{ROW_ELEM, 32'h0000_0103, 1'b0, '0},
        '{ROW_ELEM, 32'h0000_0201, 1'b0, '0},
        '{ROW_ELEM, 32'h0000_0202, 1'b0, '0},
        '{ROW_ELEM, 32'h0000_0203, 1'b0, '0},
        '{ROW_ELEM, 32'h0000_0301, 1'b0, '0},
        '{ROW_ELEM, 32'h8000_0302, 1'b0, '0},
        '{ROW_ELEM, 32'h7fff_0303, 1'b0, '0}
    };

    spiral_order_matrix_reader #(
        .MAX_SIZE   (MAX_SIZE),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_element_value (i_element_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_value     (o_out_value),
        .o_out_row       (o_out_row),
        .o_out_column    (o_out_column),
        .o_last_of_run   (o_last_of_run)
    );

    // side length in use, out of range sizes clamped
    function automatic int unsigned side_len();
        int unsigned n;
        n = 32'(size_reg);
        if (n == 0) n = 1;
        if (n > MAX_SIZE) n = MAX_SIZE;
        return n;
    endfunction

    function automatic void push_beat(int unsigned n, int unsigned r, int unsigned c,
                                      int unsigned total);
        t_spiral_beat b;
        b.value  = mat_store[r * n + c];
        b.row    = r[somr_pkg::COORD_W-1:0];
        b.column = c[somr_pkg::COORD_W-1:0];
        b.last   = (fresh_beats.size() + 1 == total);
        fresh_beats.push_back(b);
    endfunction

    // store one element; on the last one of the matrix, list the spiral
    function automatic void spiral_predict(logic [DATA_WIDTH-1:0] v);
        int unsigned n;
        int unsigned total;
        int          top;
        int          hi;
        int          i;
        n     = side_len();
        total = n * n;
        fresh_beats.delete();
        if (fill_count >= total) fill_count = 0;
        mat_store[fill_count] = v;
        fill_count++;
        if (fill_count < total) return;
        fill_count = 0;
        top = 0;
        hi  = n - 1;
        // one ring per pass: top row, right column, bottom row, left column
        while (top <= hi) begin
            for (i = top; i <= hi; i++) push_beat(n, top, i, total);
            for (i = top + 1; i <= hi; i++) push_beat(n, i, hi, total);
            if (hi > top) begin
                for (i = hi - 1; i >= top; i--) push_beat(n, hi, i, total);
                for (i = hi - 1; i > top; i--) push_beat(n, i, top, total);
            end
            top++;
            hi--;
        end
    endfunction

    function automatic logic [DATA_WIDTH-1:0] rand_element();
        case ($urandom_range(0, 19))
            0: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
            1: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // offer one element beat, wait for it to be taken, then queue its results
    task automatic send_element(input logic [DATA_WIDTH-1:0] v, input bit fixed,
                                input t_spiral_beat fixed_beat);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_element_value <= v;
        do @(posedge i_clk); while (!o_in_ready);
        elem_sent++;
        spiral_predict(v);
        if (fixed) begin
            spiral_expect_q.push_back(fixed_beat);
        end else begin
            foreach (fresh_beats[j]) spiral_expect_q.push_back(fresh_beats[j]);
        end
    endtask

    // size write once the block has drained and settled
    task automatic write_size(input logic [somr_pkg::SIZE_W-1:0] v);
        i_in_valid <= 1'b0;
        while (spiral_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        size_reg   = v;
        fill_count = 0;
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // output ready: random stalls, one long hold while the sender is blocked
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (i_rst_n && !hold_done && o_out_valid && i_in_valid && !o_in_ready) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // compare each output beat with the oldest expectation
    always @(posedge i_clk) begin
        t_spiral_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (spiral_expect_q.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("unexpected beat: value %h row %0d col %0d last %b",
                             o_out_value, o_out_row, o_out_column, o_last_of_run);
            end else begin
                want = spiral_expect_q.pop_front();
                if (o_out_value !== want.value || o_out_row !== want.row ||
                    o_out_column !== want.column || o_last_of_run !== want.last) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("beat differs: want %h r%0d c%0d l%b, got %h r%0d c%0d l%b",
                                 want.value, want.row, want.column, want.last,
                                 o_out_value, o_out_row, o_out_column, o_last_of_run);
                end
            end
        end
    end

    // stimulus
    initial begin
        int unsigned                 n;
        int unsigned                 phase;
        int unsigned                 mats;
        int unsigned                 cut;
        int unsigned                 rand_start;
        logic [somr_pkg::SIZE_W-1:0] size_val;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_table[r]) begin
            if (dir_table[r].kind == ROW_SIZE)
                write_size(dir_table[r].data[somr_pkg::SIZE_W-1:0]);
            else
                send_element(dir_table[r].data, dir_table[r].fixed, dir_table[r].beat);
        end

        // random phases: a size, whole matrices, sometimes a dropped partial load
        rand_start = elem_sent;
        phase      = 0;
        while (elem_sent - rand_start < RAND_ITEMS) begin
            if (phase == 0)
                size_val = 4'd15;
            else if (phase == 1)
                size_val = 4'd2;
            else if (phase == 3)
                size_val = 4'd8;
            else if ($urandom_range(0, 99) < 10)
                size_val = somr_pkg::SIZE_W'($urandom_range(6, 14));
            else
                size_val = somr_pkg::SIZE_W'($urandom_range(0, 5));
            write_size(size_val);
            n = side_len();
            if (phase == 1)
                mats = 3;
            else if (phase == 0 || phase == 3)
                mats = 1;
            else
                mats = $urandom_range(1, 3);
            repeat (mats) begin
                repeat (n * n) send_element(rand_element(), 1'b0, '0);
            end
            if (n > 1 && $urandom_range(0, 99) < 25) begin
                cut = $urandom_range(1, n * n - 1);
                repeat (cut) send_element(rand_element(), 1'b0, '0);
            end
            phase++;
        end

        // drain
        i_in_valid <= 1'b0;
        while (spiral_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: spiral_order_matrix_reader.f
+incdir+sv
sv/somr_pkg.sv
sv/somr_ram.sv
sv/spiral_order_matrix_reader.sv
tb/tb_spiral_order_matrix_reader.sv
